// ===== src/fdss_pkg.sv =====
`default_nettype none
package fdss_pkg;

	localparam int unsigned ValueW = 14;
	localparam int unsigned DigitW = 4;
	localparam int unsigned NumDigits = 4;

	localparam logic [ValueW-1:0] SAT_MAX = 14'd9999;

	// Reciprocal constants: floor(x / k) = (x * RECIP) >> SHIFT over the range each stage sees
	localparam logic [13:0] THOU_RECIP = 14'd8389;
	localparam int unsigned THOU_SHIFT = 23;
	localparam logic [12:0] HUND_RECIP = 13'd5243;
	localparam int unsigned HUND_SHIFT = 19;
	localparam logic [7:0]  TEN_RECIP  = 8'd205;
	localparam int unsigned TEN_SHIFT  = 11;

	localparam logic [3:0] SEL_BLANK = 4'hF;
	localparam logic [7:0] SEG_BLANK = 8'hFF;

	localparam logic [1:0] POS_THOUSANDS = 2'd0;
	localparam logic [1:0] POS_HUNDREDS  = 2'd1;
	localparam logic [1:0] POS_TENS      = 2'd2;
	localparam logic [1:0] POS_UNITS     = 2'd3;

	typedef struct packed {
		logic [NumDigits-1:0][DigitW-1:0] digits; // index 0 is thousands
		logic [1:0]                       first;  // most significant position shown
	} fdss_entry_t;

	function automatic logic [7:0] seg_code(input logic [DigitW-1:0] digit);
		logic [7:0] code;
		case (digit)
			4'd0: code = 8'hC0;
			4'd1: code = 8'hF9;
			4'd2: code = 8'hA4;
			4'd3: code = 8'hB0;
			4'd4: code = 8'h99;
			4'd5: code = 8'h92;
			4'd6: code = 8'h82;
			4'd7: code = 8'hF8;
			4'd8: code = 8'h80;
			4'd9: code = 8'h90;
			default: code = SEG_BLANK;
		endcase
		return code;
	endfunction

	function automatic logic [3:0] sel_code(input logic [1:0] pos);
		logic [3:0] code;
		case (pos)
			POS_THOUSANDS: code = 4'hE;
			POS_HUNDREDS:  code = 4'hD;
			POS_TENS:      code = 4'hB;
			POS_UNITS:     code = 4'h7;
			default:       code = SEL_BLANK;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

// ===== src/four_digit_seven_segment_scan.sv =====
// Channel  | Direction | Handshake                   | Payload
// value    | in        | value_valid / value_ready   | value[13:0]
// result   | out       | result_valid / result_ready | digit_select_n[3:0], segments_n[7:0], last
//
// A number yields two words per digit shown, one word a cycle while result_ready is high,
// set by the word sequencer in the back end.
// An accepted value passes the 7-stage digit split, the queue and the output register before its first word.
// arst_n clears all valid and sequencing state; no clearing pass is needed.
// The digit split stalls only when the queue is full; the sequencer stalls on result_ready.
`default_nettype none
module four_digit_seven_segment_scan import fdss_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [ValueW-1:0] value,
	input  wire logic              value_valid,
	output logic                   value_ready,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output logic [3:0]             digit_select_n,
	output logic [7:0]             segments_n,
	output logic                   last
);

	fdss_entry_t front_entry, head_entry;
	logic        front_valid, front_ready;
	logic        head_valid, head_pop;

	fdss_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.entry       (front_entry),
		.entry_valid (front_valid),
		.entry_ready (front_ready)
	);

	fdss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_entry (front_entry),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_entry (head_entry),
		.rd_valid (head_valid),
		.rd_pop   (head_pop)
	);

	fdss_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head_entry),
		.head_valid     (head_valid),
		.head_pop       (head_pop),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.digit_select_n (digit_select_n),
		.segments_n     (segments_n),
		.last           (last)
	);

endmodule
`default_nettype wire

// ===== src/fdss_front.sv =====
`default_nettype none
module fdss_front import fdss_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [ValueW-1:0] value,
	input  wire logic              value_valid,
	output logic                   value_ready,
	output fdss_entry_t            entry,
	output logic                   entry_valid,
	input  wire logic              entry_ready
);

	logic adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic [ValueW-1:0] v_s1, v_s2;
	logic [1:0]        first_s1, first_s2, first_s3, first_s4, first_s5, first_s6;
	logic [3:0]        th_s2, th_s3, th_s4, th_s5, th_s6;
	logic [9:0]        r1_s3, r1_s4;
	logic [3:0]        hu_s4, hu_s5, hu_s6;
	logic [6:0]        r2_s5, r2_s6;
	logic [3:0]        te_s6;
	fdss_entry_t       entry_s7;

	logic [ValueW-1:0] v_sat;
	logic [1:0]        first_in;
	logic [27:0]       prod_th;
	logic [13:0]       rem_th;
	logic [22:0]       prod_hu;
	logic [9:0]        rem_hu;
	logic [14:0]       prod_te;
	logic [6:0]        rem_te;

	// Stall the whole pipe only while the last stage holds a transaction the queue cannot take
	assign adv         = !vld_s7 || entry_ready;
	assign value_ready = adv;

	always_comb begin
		v_sat = (value > SAT_MAX) ? SAT_MAX : value;
		if (v_sat >= 14'd1000) begin
			first_in = POS_THOUSANDS;
		end else if (v_sat >= 14'd100) begin
			first_in = POS_HUNDREDS;
		end else if (v_sat >= 14'd10) begin
			first_in = POS_TENS;
		end else begin
			first_in = POS_UNITS;
		end
	end

	assign prod_th = {14'd0, v_s1} * {14'd0, THOU_RECIP};
	assign rem_th  = v_s2 - ({10'd0, th_s2} * 14'd1000);
	assign prod_hu = {13'd0, r1_s3} * {10'd0, HUND_RECIP};
	assign rem_hu  = r1_s4 - ({6'd0, hu_s4} * 10'd100);
	assign prod_te = {8'd0, r2_s5} * {7'd0, TEN_RECIP};
	assign rem_te  = r2_s6 - ({3'd0, te_s6} * 7'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= value_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1     <= v_sat;
			first_s1 <= first_in;

			v_s2     <= v_s1;
			th_s2    <= prod_th[THOU_SHIFT+3:THOU_SHIFT];
			first_s2 <= first_s1;

			r1_s3    <= rem_th[9:0];
			th_s3    <= th_s2;
			first_s3 <= first_s2;

			r1_s4    <= r1_s3;
			hu_s4    <= prod_hu[HUND_SHIFT+3:HUND_SHIFT];
			th_s4    <= th_s3;
			first_s4 <= first_s3;

			r2_s5    <= rem_hu[6:0];
			hu_s5    <= hu_s4;
			th_s5    <= th_s4;
			first_s5 <= first_s4;

			r2_s6    <= r2_s5;
			te_s6    <= prod_te[TEN_SHIFT+3:TEN_SHIFT];
			hu_s6    <= hu_s5;
			th_s6    <= th_s5;
			first_s6 <= first_s5;

			entry_s7.digits[0] <= th_s6;
			entry_s7.digits[1] <= hu_s6;
			entry_s7.digits[2] <= te_s6;
			entry_s7.digits[3] <= rem_te[3:0];
			entry_s7.first     <= first_s6;
		end
	end

	assign entry       = entry_s7;
	assign entry_valid = vld_s7;

endmodule
`default_nettype wire

// ===== src/fdss_queue.sv =====
`default_nettype none
module fdss_queue import fdss_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire fdss_entry_t  wr_entry,
	input  wire logic         wr_valid,
	output logic              wr_ready,
	output fdss_entry_t       rd_entry,
	output logic              rd_valid,
	input  wire logic         rd_pop
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	fdss_entry_t     mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push, pop;

	assign wr_ready = (count_q != CntW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule
`default_nettype wire

// ===== src/fdss_back.sv =====
`default_nettype none
module fdss_back import fdss_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire fdss_entry_t head,
	input  wire logic        head_valid,
	output logic             head_pop,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [3:0]       digit_select_n,
	output logic [7:0]       segments_n,
	output logic             last
);

	logic       busy_q;
	logic       blank_q;   // next word is the blank after a pattern
	logic [1:0] pos_q;
	logic       out_valid_q;
	logic [3:0] sel_q;
	logic [7:0] seg_q;
	logic       last_q;

	logic       load;
	logic [1:0] pos_now;

	assign load     = head_valid && (!out_valid_q || result_ready);
	assign pos_now  = busy_q ? pos_q : head.first;
	assign head_pop = load && blank_q && (pos_q == POS_UNITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			blank_q     <= 1'b0;
			pos_q       <= POS_THOUSANDS;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				if (!blank_q) begin
					blank_q <= 1'b1;
					busy_q  <= 1'b1;
					pos_q   <= pos_now;
				end else begin
					blank_q <= 1'b0;
					if (pos_q == POS_UNITS) begin
						busy_q <= 1'b0;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (!blank_q) begin
				sel_q  <= sel_code(pos_now);
				seg_q  <= seg_code(head.digits[pos_now]);
				last_q <= 1'b0;
			end else begin
				sel_q  <= SEL_BLANK;
				seg_q  <= SEG_BLANK;
				last_q <= (pos_q == POS_UNITS);
			end
		end
	end

	assign result_valid   = out_valid_q;
	assign digit_select_n = sel_q;
	assign segments_n     = seg_q;
	assign last           = last_q;

endmodule
`default_nettype wire

// ===== src/fdss_checker.sv =====
`default_nettype none
module fdss_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [3:0]  digit_select_n,
	input wire logic [7:0]  segments_n,
	input wire logic        last
);

	// A stalled transaction holds its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(digit_select_n) && $stable(segments_n) && $stable(last))
		else $error("result word changed while stalled");

	// The end marker sits only on a blank word
	a_last_blank: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> digit_select_n == 4'hF && segments_n == 8'hFF)
		else $error("last on a non-blank word");

	// A pattern word drives exactly one digit, with the dp dark
	a_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && digit_select_n != 4'hF |->
			$onehot(~digit_select_n) && segments_n[7] && !last)
		else $error("malformed pattern word");

	// A blank word follows every pattern word
	a_blank_after: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && digit_select_n != 4'hF |=>
			!result_valid || digit_select_n == 4'hF)
		else $error("pattern word not followed by blank");

endmodule

bind four_digit_seven_segment_scan fdss_checker u_fdss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.digit_select_n (digit_select_n),
	.segments_n     (segments_n),
	.last           (last)
);
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import fdss_pkg::*;

	typedef struct packed {
		logic [3:0] sel;
		logic [7:0] seg;
		logic       last;
	} scan_word_t;

	// Segment codes for digits 9 down to 0, and digit selects from units down to thousands
	localparam logic [9:0][7:0] DIGIT_SEGS = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
		8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};
	localparam logic [3:0][3:0] POSITION_SEL = {4'h7, 4'hB, 4'hD, 4'hE};
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES = 12;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic [ValueW-1:0] value = '0;
	logic              value_valid = 1'b0;
	logic              value_ready;
	logic              result_valid;
	logic              result_ready = 1'b0;
	logic [3:0]        digit_select_n;
	logic [7:0]        segments_n;
	logic              last;

	scan_word_t  pending_words[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	four_digit_seven_segment_scan i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.value          (value),
		.value_valid    (value_valid),
		.value_ready    (value_ready),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.digit_select_n (digit_select_n),
		.segments_n     (segments_n),
		.last           (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expected display words for one number, most significant digit first
	function automatic void predict_scan_words(input logic [ValueW-1:0] v);
		int unsigned n;
		int unsigned lead;
		int unsigned dig [NumDigits];
		scan_word_t w;
		n = (v > SAT_MAX) ? SAT_MAX : v;
		dig[0] = n / 1000;
		dig[1] = (n / 100) % 10;
		dig[2] = (n / 10) % 10;
		dig[3] = n % 10;
		if (n >= 1000)
			lead = POS_THOUSANDS;
		else if (n >= 100)
			lead = POS_HUNDREDS;
		else if (n >= 10)
			lead = POS_TENS;
		else
			lead = POS_UNITS;
		for (int p = lead; p < NumDigits; p++) begin
			w.sel = POSITION_SEL[p];
			w.seg = DIGIT_SEGS[dig[p]];
			w.last = 1'b0;
			pending_words.push_back(w);
			w.sel = SEL_BLANK;
			w.seg = SEG_BLANK;
			w.last = (p == POS_UNITS);
			pending_words.push_back(w);
		end
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_value(input logic [ValueW-1:0] v);
		// Idle each cycle with the set probability before raising valid
		while ($urandom_range(99) < send_idle_pct) begin
			value_valid <= 1'b0;
			@(posedge clk);
		end
		value <= v;
		value_valid <= 1'b1;
		do @(posedge clk); while (!value_ready);
		predict_scan_words(v);
	endtask

	// Drop valid and wait on the clock so the next raise falls in a later step
	task automatic park_sender();
		value_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_scan_drained();
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	function automatic logic [ValueW-1:0] random_value();
		int unsigned cls;
		cls = $urandom_range(9);
		case (cls)
			0, 1: return ValueW'($urandom_range(9));
			2, 3: return ValueW'($urandom_range(99, 10));
			4, 5: return ValueW'($urandom_range(999, 100));
			6, 7, 8: return ValueW'($urandom_range(9999, 1000));
			default: return ValueW'($urandom_range(16383, 10000));
		endcase
	endfunction

	task automatic test_directed_values();
		logic [ValueW-1:0] vals [$];
		vals = '{14'd0, 14'd9, 14'd10, 14'd99, 14'd100, 14'd999, 14'd1000, 14'd9999,
			14'd10000, 14'd16383, 14'd8192, 14'd1234, 14'd5678, 14'd9012, 14'd3007,
			14'd1020, 14'd8060, 14'd7, 14'd45, 14'd306};
		foreach (vals[i])
			send_value(vals[i]);
	endtask

	task automatic test_random_values(input int unsigned count);
		repeat (count)
			send_value(random_value());
	endtask

	// Hold off until the scan queue is empty, then send again with the design idle
	task automatic test_drained_restart();
		park_sender();
		wait_scan_drained();
		test_random_values(5);
	endtask

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && result_valid && result_ready) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word", {digit_select_n, segments_n}, 0);
			end else begin
				if (digit_select_n !== pending_words[0].sel)
					report_mismatch("digit_select_n", digit_select_n, pending_words[0].sel);
				if (segments_n !== pending_words[0].seg)
					report_mismatch("segments_n", segments_n, pending_words[0].seg);
				if (last !== pending_words[0].last)
					report_mismatch("last", last, pending_words[0].last);
				void'(pending_words.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((value_valid && value_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 35;
		recv_idle_pct = 52;
		test_directed_values();
		test_random_values(30);
		test_drained_restart();

		send_idle_pct = 52;
		recv_idle_pct = 35;
		test_random_values(30);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_values(15);

		park_sender();
		wait_scan_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
